[hdl/gwm_pkg.sv]
// Shared types, constants and helpers for the glob wildcard matcher.
// No dependencies; every other file in hdl/ imports this package.
package gwm_pkg;

  // longest pattern held and number of automaton positions (one past the end)
  localparam int MAX_PATTERN = 32;
  localparam int NPOS        = MAX_PATTERN + 1;
  localparam int POS_W       = $clog2(NPOS);

  // configuration port
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 3;
  localparam int LEN_W      = 6;
  localparam int NUM_WORDS  = 4;
  localparam int CHARS_HELD = NUM_WORDS * 8;

  localparam logic [CFG_IDX_W-1:0] REG_CHARS_0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHARS_1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHARS_2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CHARS_3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH  = 3'd4;

  // special pattern characters
  localparam logic [7:0] CHAR_STAR  = 8'h2A;
  localparam logic [7:0] CHAR_QMARK = 8'h3F;
  localparam logic [7:0] CHAR_UC_A  = 8'h41;
  localparam logic [7:0] CHAR_UC_Z  = 8'h5A;
  localparam logic [7:0] CASE_DIFF  = 8'h20;

  // input transaction
  typedef struct packed {
    logic [7:0] subject_byte;
    logic       end_of_subject;
    logic       empty_subject;
  } in_t;

  // output transaction
  typedef struct packed {
    logic matched;
    logic final_verdict;
  } out_t;

  // decoded pattern info for one position
  typedef struct packed {
    logic [7:0] char_fold;
    logic       star;
    logic       qmark;
    logic       in_len;
    logic       keep;
  } pat_pos_t;

  // per-cycle control broadcast to every cell
  typedef struct packed {
    logic s1_load;
    logic commit;
    logic use_s1;
    logic sel_start;
    logic empty;
  } cell_ctl_t;

  // ascii lower-casing
  function automatic logic [7:0] fold(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= CHAR_UC_A && c <= CHAR_UC_Z) begin
      r = c + CASE_DIFF;
    end
    return r;
  endfunction

endpackage

[hdl/gwm_cfg.sv]
// Pattern configuration registers and per-position pattern decode.
// Depends on gwm_pkg.
module gwm_cfg (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [gwm_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [gwm_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  output gwm_pkg::pat_pos_t                 pat_o [gwm_pkg::NPOS],
  output logic [gwm_pkg::POS_W-1:0]         eff_len_o
);
  import gwm_pkg::*;

  logic [CFG_DATA_W-1:0] chars_q [NUM_WORDS];
  logic [LEN_W-1:0]      len_q;

  // register writes, unknown indexes ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int w = 0; w < NUM_WORDS; w++) begin
        chars_q[w] <= '0;
      end
      len_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_CHARS_0: chars_q[0] <= cfg_wdata_i;
        REG_CHARS_1: chars_q[1] <= cfg_wdata_i;
        REG_CHARS_2: chars_q[2] <= cfg_wdata_i;
        REG_CHARS_3: chars_q[3] <= cfg_wdata_i;
        REG_LENGTH:  len_q      <= cfg_wdata_i[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp length to the positions held
  always_comb begin
    if (32'(len_q) > 32'(MAX_PATTERN)) begin
      eff_len_o = POS_W'(MAX_PATTERN);
    end else begin
      eff_len_o = POS_W'(len_q);
    end
  end

  // decode each position; characters past the held ones read as zero
  for (genvar i = 0; i < NPOS; i++) begin : g_pos
    logic [7:0] ch;
    if (i < CHARS_HELD && i < MAX_PATTERN) begin : g_held
      assign ch = chars_q[i / 8][(i % 8) * 8 +: 8];
    end else begin : g_zero
      assign ch = 8'h00;
    end
    assign pat_o[i].char_fold = fold(ch);
    assign pat_o[i].star      = (ch == CHAR_STAR);
    assign pat_o[i].qmark     = (ch == CHAR_QMARK);
    assign pat_o[i].in_len    = (32'(i) <  32'(eff_len_o));
    assign pat_o[i].keep      = (32'(i) <= 32'(eff_len_o));
  end

endmodule

[hdl/gwm_cell.sv]
// One pattern position of the matcher: holds its active bit for the pending
// transaction and the committed state. Depends on gwm_pkg.
module gwm_cell (
  input  logic                 clk_i,
  input  gwm_pkg::cell_ctl_t   ctl_i,
  input  gwm_pkg::pat_pos_t    pat_i,
  input  logic [7:0]           subj_fold_i,
  input  logic                 start_i,
  input  logic                 cur_cin_i,
  output logic                 cur_cout_o,
  input  logic                 tok_i,
  output logic                 tok_o,
  input  logic                 cl_cin_i,
  output logic                 cl_cout_o,
  output logic                 cl_o
);
  import gwm_pkg::*;

  logic raw_q, raw_d;
  logic act_q;
  logic star_eff, src, cur, hit;

  assign star_eff = pat_i.star & pat_i.in_len;

  // active bit before the byte: start, pending result or committed state
  always_comb begin
    if (ctl_i.sel_start) begin
      src = start_i;
    end else if (ctl_i.use_s1) begin
      src = raw_q;
    end else begin
      src = act_q;
    end
  end

  // closure across stars, rippling in from the left neighbor
  assign cur        = (src & pat_i.keep) | cur_cin_i;
  assign cur_cout_o = cur & star_eff;

  // consume the byte: a literal or '?' hands a token to the right
  assign hit   = pat_i.qmark | (pat_i.char_fold == subj_fold_i);
  assign tok_o = cur & pat_i.in_len & ~pat_i.star & hit;

  // raw next bit: a star stays, a token arrives from the left; an empty subject loads the start bit
  assign raw_d = ctl_i.empty ? start_i : ((cur & star_eff) | tok_i);

  // second closure on the pending bit for the result
  assign cl_o      = raw_q | cl_cin_i;
  assign cl_cout_o = cl_o & star_eff;

  // pending bit and committed state
  always_ff @(posedge clk_i) begin
    if (ctl_i.s1_load) begin
      raw_q <= raw_d;
    end
    if (ctl_i.commit) begin
      act_q <= cl_o;
    end
  end

endmodule

[hdl/glob_wildcard_matcher_core.sv]
// Top level of the glob wildcard matcher: cell row, control and output register.
// Depends on gwm_pkg, gwm_cfg and gwm_cell.

// Case-insensitive glob matcher ('*' any run, '?' any one character) over a
// subject streamed one byte per transaction. It takes one byte every clock
// while the output is not stalled and returns one result per byte, formed
// from the pending stage and held in an output register that decouples the
// two sides. Each byte passes a row of 33 cells, one per pattern position;
// the star closure ripples through that row once when the byte enters and
// once when its result is formed, and that ripple sets the clock
// period. Write the pattern registers only while no transaction is in flight.
module glob_wildcard_matcher_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  gwm_pkg::in_t                    in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output gwm_pkg::out_t                   out_data_o,
  input  logic                            cfg_we_i,
  input  logic [gwm_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [gwm_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);
  import gwm_pkg::*;

  pat_pos_t         pat   [NPOS];
  logic [POS_W-1:0] eff_len;
  cell_ctl_t        ctl;
  logic [7:0]       subj_fold;
  logic [NPOS:0]    cur_c, tok_c, cl_c;
  logic [NPOS-1:0]  cl_vec;

  logic s1_valid_q, s1_valid_d, s1_last_q, s1_last_d;
  logic start_q, start_d;
  logic out_valid_q, out_valid_d;
  out_t out_q, out_d;
  logic in_acc, s1_move;

  // configuration
  gwm_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .pat_o       (pat),
    .eff_len_o   (eff_len)
  );

  // handshake
  assign s1_move    = s1_valid_q & (~out_valid_q | out_ready_i);
  assign in_ready_o = ~s1_valid_q | s1_move;
  assign in_acc     = in_valid_i & in_ready_o;
  assign subj_fold  = fold(in_data_i.subject_byte);

  // control broadcast to the cells
  assign ctl.s1_load   = in_acc;
  assign ctl.commit    = s1_move;
  assign ctl.use_s1    = s1_valid_q;
  assign ctl.sel_start = s1_valid_q ? s1_last_q : start_q;
  assign ctl.empty     = in_data_i.empty_subject;

  // row of position cells
  assign cur_c[0] = 1'b0;
  assign tok_c[0] = 1'b0;
  assign cl_c[0]  = 1'b0;
  for (genvar i = 0; i < NPOS; i++) begin : g_cell
    gwm_cell u_cell (
      .clk_i       (clk_i),
      .ctl_i       (ctl),
      .pat_i       (pat[i]),
      .subj_fold_i (subj_fold),
      .start_i     (i == 0),
      .cur_cin_i   (cur_c[i]),
      .cur_cout_o  (cur_c[i+1]),
      .tok_i       (tok_c[i]),
      .tok_o       (tok_c[i+1]),
      .cl_cin_i    (cl_c[i]),
      .cl_cout_o   (cl_c[i+1]),
      .cl_o        (cl_vec[i])
    );
  end

  // next-state logic for control and the output register
  always_comb begin
    s1_valid_d  = in_acc | (s1_valid_q & ~s1_move);
    s1_last_d   = s1_last_q;
    start_d     = start_q;
    out_valid_d = s1_move | (out_valid_q & ~out_ready_i);
    out_d       = out_q;
    if (in_acc) begin
      s1_last_d = in_data_i.end_of_subject | in_data_i.empty_subject;
    end
    if (s1_move) begin
      start_d             = s1_last_q;
      out_d.matched       = cl_vec[eff_len];
      out_d.final_verdict = s1_last_q;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s1_last_q   <= 1'b0;
      start_q     <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      s1_last_q   <= s1_last_d;
      start_q     <= start_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // nothing ripples past the last position
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cur_c[NPOS] && !tok_c[NPOS] && !cl_c[NPOS])
    else $error("closure or token ran past the last position");

  // a transaction leaving the pending stage shows up at the output
  a_move_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_move |=> out_valid_o)
    else $error("pending transaction lost on its way to the output");

  // ending a subject returns the automaton to the start
  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_move && s1_last_q) |=> start_q)
    else $error("state not restarted after end of subject");

  // final verdict on the output matches the pending end flag
  a_final_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_move |=> (out_data_o.final_verdict == $past(s1_last_q)))
    else $error("final verdict does not follow the end flag");

endmodule

[tb/tb_top.sv]
// Self-checking testbench for glob_wildcard_matcher_core: a directed table, then random phases.
// Depends on gwm_pkg and the matcher RTL; expected verdicts come from a predictor kept in here.
module tb_top;
  import gwm_pkg::*;

  localparam int N_ITEMS     = 1400;
  localparam int CALM_ITEMS  = 150;
  localparam int STALL_LIMIT = 2000;
  localparam int MAX_SHOWN   = 10;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

  typedef logic [NPOS-1:0] pos_vec_t;
  localparam pos_vec_t START_POS = {{(NPOS-1){1'b0}}, 1'b1};

  typedef logic [7:0] byte_q_t [$];

  typedef enum logic [0:0] {ROW_CFG, ROW_ITEM} row_kind_e;

  // one row of the directed table: a register write or an input transaction
  typedef struct packed {
    row_kind_e              kind;
    logic [CFG_IDX_W-1:0]   idx;
    logic [CFG_DATA_W-1:0]  data;
    in_t                    item;
    logic                   typed;
    out_t                   want;
  } stim_row_t;

  logic                   clk       = 1'b0;
  logic                   rst_n     = 1'b0;
  logic                   in_valid  = 1'b0;
  logic                   in_ready;
  in_t                    in_data   = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  out_t                   out_data;
  logic                   cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  // mirror of the pattern registers and the live position set
  logic [CFG_DATA_W-1:0]  pat_word [NUM_WORDS] = '{default: '0};
  logic [LEN_W-1:0]       pat_len  = '0;
  pos_vec_t               live_pos = START_POS;

  out_t verdict_q [$];
  int   items_sent   = 0;
  int   results_seen = 0;
  int   errors       = 0;
  int   in_gap_pct   = 0;
  int   quiet_cycles = 0;
  bit   calm         = 1'b0;

  // letters of both cases plus the neighbors of the a-z and A-Z ranges
  logic [7:0] char_pool [10] = '{8'h61, 8'h41, 8'h62, 8'h42, 8'h40,
                                 8'h5B, 8'h60, 8'h7B, 8'h7A, 8'h5A};

  glob_wildcard_matcher_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // pattern character at a position, zero past the held characters
  function automatic logic [7:0] pat_byte(int idx);
    if (idx >= CHARS_HELD) return 8'h00;
    return pat_word[idx / 8][(idx % 8) * 8 +: 8];
  endfunction

  function automatic int eff_len();
    return (pat_len > MAX_PATTERN) ? MAX_PATTERN : int'(pat_len);
  endfunction

  function automatic logic [7:0] to_lower(logic [7:0] c);
    return (c >= CHAR_UC_A && c <= CHAR_UC_Z) ? c + CASE_DIFF : c;
  endfunction

  // drop positions past the length, then spread across stars
  function automatic pos_vec_t close_stars(pos_vec_t s, int len);
    for (int i = len + 1; i < NPOS; i++) s[i] = 1'b0;
    for (int i = 0; i < len; i++) begin
      if (s[i] && pat_byte(i) == CHAR_STAR) s[i + 1] = 1'b1;
    end
    return s;
  endfunction

  // advance the position set by one subject byte and form its verdict
  function automatic out_t glob_step(in_t it);
    pos_vec_t   cur;
    pos_vec_t   nxt;
    logic [7:0] p;
    int         len;
    out_t       res;
    len = eff_len();
    if (it.empty_subject) begin
      cur = close_stars(START_POS, len);
      res.matched       = cur[len];
      res.final_verdict = 1'b1;
      live_pos          = START_POS;
    end else begin
      cur = close_stars(live_pos, len);
      nxt = '0;
      for (int i = 0; i < len; i++) begin
        p = pat_byte(i);
        if (!cur[i]) continue;
        if (p == CHAR_STAR) nxt[i] = 1'b1;
        else if (p == CHAR_QMARK || to_lower(p) == to_lower(it.subject_byte)) nxt[i + 1] = 1'b1;
      end
      nxt = close_stars(nxt, len);
      res.matched       = nxt[len];
      res.final_verdict = it.end_of_subject;
      live_pos          = it.end_of_subject ? START_POS : nxt;
    end
    return res;
  endfunction

  function automatic logic [7:0] rand_char();
    if ($urandom_range(0, 4) == 0) return 8'($urandom);
    return char_pool[$urandom_range(0, 9)];
  endfunction

  function automatic in_t empty_item();
    in_t it;
    it.subject_byte   = 8'($urandom);
    it.end_of_subject = 1'($urandom);
    it.empty_subject  = 1'b1;
    return it;
  endfunction

  // subject that fits the current pattern, sometimes damaged or plain random
  function automatic byte_q_t make_subject();
    byte_q_t    s;
    logic [7:0] c;
    int         pos;
    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(0, 6)) s.push_back(rand_char());
      return s;
    end
    for (int i = 0; i < eff_len(); i++) begin
      c = pat_byte(i);
      if (c == CHAR_STAR) begin
        repeat ($urandom_range(0, 3)) s.push_back(rand_char());
      end else if (c == CHAR_QMARK) begin
        s.push_back(8'($urandom));
      end else begin
        if ((c | CASE_DIFF) >= (CHAR_UC_A | CASE_DIFF) && (c | CASE_DIFF) <= (CHAR_UC_Z | CASE_DIFF)
            && $urandom_range(0, 1) == 1) begin
          c = c ^ CASE_DIFF;
        end
        s.push_back(c);
      end
    end
    if (s.size() > 0 && $urandom_range(0, 2) == 0) begin
      pos = $urandom_range(0, s.size() - 1);
      case ($urandom_range(0, 2))
        0: s[pos] = rand_char();
        1: s.delete(pos);
        default: s.insert(pos, rand_char());
      endcase
    end
    return s;
  endfunction

  function automatic stim_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    stim_row_t r;
    r      = '0;
    r.kind = ROW_CFG;
    r.idx  = idx;
    r.data = data;
    return r;
  endfunction

  function automatic stim_row_t item_row(logic [7:0] b, logic last, logic empty,
                                         logic typed, logic m, logic f);
    stim_row_t r;
    r                     = '0;
    r.kind                = ROW_ITEM;
    r.item.subject_byte   = b;
    r.item.end_of_subject = last;
    r.item.empty_subject  = empty;
    r.typed               = typed;
    r.want.matched        = m;
    r.want.final_verdict  = f;
    return r;
  endfunction

  task automatic flag_error(string what);
    errors++;
    if (errors <= MAX_SHOWN) $display("mismatch: %s", what);
  endtask

  // drop valid and wait for every outstanding verdict plus the pipeline tail
  task automatic settle();
    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // one register write; the caller lowers the write enable after a batch
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      REG_CHARS_0: pat_word[0] = data;
      REG_CHARS_1: pat_word[1] = data;
      REG_CHARS_2: pat_word[2] = data;
      REG_CHARS_3: pat_word[3] = data;
      REG_LENGTH:  pat_len = data[LEN_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // present one transaction and record its expected verdict once accepted
  task automatic send_item(input in_t it, input logic typed, input out_t want);
    out_t guess;
    if (!calm && $urandom_range(0, 99) < in_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    guess = glob_step(it);
    verdict_q.push_back(typed ? want : guess);
    items_sent++;
  endtask

  // a subject byte by byte, with the odd empty-subject transaction thrown in
  task automatic send_subject(input byte_q_t subj, input bit partial);
    in_t it;
    if (subj.size() == 0 && !partial) send_item(empty_item(), 1'b0, '0);
    foreach (subj[k]) begin
      if ($urandom_range(0, 39) == 0) send_item(empty_item(), 1'b0, '0);
      it.subject_byte   = subj[k];
      it.end_of_subject = (k == subj.size() - 1) && !partial;
      it.empty_subject  = 1'b0;
      send_item(it, 1'b0, '0);
    end
  endtask

  // output side stalls in bursts, with calm stretches in between
  initial begin
    int stretch;
    int stall_pct;
    stretch   = 0;
    stall_pct = 0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (stretch == 0) begin
        stretch = $urandom_range(50, 200);
        case ($urandom_range(0, 2))
          0: stall_pct = 0;
          1: stall_pct = 8;
          default: stall_pct = 30;
        endcase
      end
      stretch--;
      if (!calm && $urandom_range(0, 99) < stall_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // compare each result with the oldest expected verdict
  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (verdict_q.size() == 0) begin
        flag_error($sformatf("result %0d arrived with nothing expected (%b)",
                             results_seen, out_data));
      end else begin
        want = verdict_q.pop_front();
        if (out_data.matched !== want.matched)
          flag_error($sformatf("result %0d matched: expected %b got %b",
                               results_seen, want.matched, out_data.matched));
        if (out_data.final_verdict !== want.final_verdict)
          flag_error($sformatf("result %0d final_verdict: expected %b got %b",
                               results_seen, want.final_verdict, out_data.final_verdict));
      end
      results_seen++;
    end
  end

  // watchdog on cycles without any transaction
  initial begin
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // reset, directed table, random phases, drain
  initial begin
    stim_row_t             stim_tab [$];
    logic [CFG_DATA_W-1:0] words [NUM_WORDS];
    logic [CFG_DATA_W-1:0] len_data;
    logic [7:0]            c;
    int                    r;
    int                    raw_len;
    bit                    in_cfg;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty pattern after reset: only the empty subject matches
    stim_tab.push_back(item_row(8'hFF, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1));
    stim_tab.push_back(item_row(8'h00, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0));
    stim_tab.push_back(item_row(8'hFF, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1));
    // lone star; a write to an unmapped index changes nothing
    stim_tab.push_back(cfg_row(REG_UNMAPPED, '1));
    stim_tab.push_back(cfg_row(REG_CHARS_0, 64'h2A));
    stim_tab.push_back(cfg_row(REG_LENGTH, 64'd1));
    stim_tab.push_back(item_row(8'h00, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1));
    stim_tab.push_back(item_row("x", 1'b1, 1'b0, 1'b1, 1'b1, 1'b1));
    // "A?c" matched case-insensitively, junk above the length field
    stim_tab.push_back(cfg_row(REG_CHARS_0, 64'h633F41));
    stim_tab.push_back(cfg_row(REG_LENGTH, 64'hFFFF_FFFF_FFFF_FFC3));
    stim_tab.push_back(cfg_row(REG_UNMAPPED, '0));
    stim_tab.push_back(item_row("a", 1'b0, 1'b0, 1'b1, 1'b0, 1'b0));
    stim_tab.push_back(item_row("Z", 1'b0, 1'b0, 1'b1, 1'b0, 1'b0));
    stim_tab.push_back(item_row("C", 1'b1, 1'b0, 1'b1, 1'b1, 1'b1));
    stim_tab.push_back(item_row(8'h00, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1));
    // oversized length clamps to the full 32: 31 stars then a question mark
    stim_tab.push_back(cfg_row(REG_CHARS_0, 64'h2A2A_2A2A_2A2A_2A2A));
    stim_tab.push_back(cfg_row(REG_CHARS_1, 64'h2A2A_2A2A_2A2A_2A2A));
    stim_tab.push_back(cfg_row(REG_CHARS_2, 64'h2A2A_2A2A_2A2A_2A2A));
    stim_tab.push_back(cfg_row(REG_CHARS_3, 64'h3F2A_2A2A_2A2A_2A2A));
    stim_tab.push_back(cfg_row(REG_LENGTH, '1));
    stim_tab.push_back(item_row(8'hFF, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1));
    stim_tab.push_back(item_row(8'h80, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1));
    // stars only
    stim_tab.push_back(cfg_row(REG_LENGTH, 64'd31));
    stim_tab.push_back(item_row(8'h00, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1));
    // all-ones pattern bytes
    stim_tab.push_back(cfg_row(REG_CHARS_0, '1));
    stim_tab.push_back(cfg_row(REG_LENGTH, 64'd2));
    stim_tab.push_back(item_row(8'hFF, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
    stim_tab.push_back(item_row(8'hFF, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1));
    // zero bytes compare as ordinary characters
    stim_tab.push_back(cfg_row(REG_CHARS_0, 64'h2A00));
    stim_tab.push_back(cfg_row(REG_LENGTH, 64'd3));
    stim_tab.push_back(item_row(8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
    stim_tab.push_back(item_row("q", 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
    stim_tab.push_back(item_row(8'h00, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
    // pattern shortened in the middle of a subject
    stim_tab.push_back(cfg_row(REG_CHARS_0, 64'h6261));
    stim_tab.push_back(cfg_row(REG_LENGTH, 64'd2));
    stim_tab.push_back(item_row("A", 1'b0, 1'b0, 1'b1, 1'b0, 1'b0));
    stim_tab.push_back(cfg_row(REG_LENGTH, 64'd1));
    stim_tab.push_back(item_row("b", 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
    stim_tab.push_back(item_row("a", 1'b1, 1'b0, 1'b0, 1'b0, 1'b0));

    // walk the directed table
    in_gap_pct = 20;
    in_cfg     = 1'b0;
    foreach (stim_tab[k]) begin
      if (stim_tab[k].kind == ROW_CFG) begin
        if (!in_cfg) settle();
        in_cfg = 1'b1;
        write_reg(stim_tab[k].idx, stim_tab[k].data);
      end else begin
        if (in_cfg) cfg_we <= 1'b0;
        in_cfg = 1'b0;
        send_item(stim_tab[k].item, stim_tab[k].typed, stim_tab[k].want);
      end
    end

    // random phases: new pattern, then a handful of subjects
    while (items_sent < N_ITEMS) begin
      calm = (items_sent >= N_ITEMS - CALM_ITEMS);
      case ($urandom_range(0, 2))
        0: in_gap_pct = 0;
        1: in_gap_pct = 10;
        default: in_gap_pct = 40;
      endcase

      r = $urandom_range(0, 99);
      if (r < 70) raw_len = $urandom_range(0, 8);
      else if (r < 90) raw_len = $urandom_range(9, 20);
      else if (r < 96) raw_len = $urandom_range(21, 32);
      else raw_len = $urandom_range(33, 63);

      for (int i = 0; i < CHARS_HELD; i++) begin
        r = $urandom_range(0, 99);
        if (i >= raw_len) c = 8'($urandom);
        else if (r < 25) c = CHAR_STAR;
        else if (r < 40) c = CHAR_QMARK;
        else if (r < 85) c = rand_char();
        else c = 8'($urandom);
        words[i / 8][(i % 8) * 8 +: 8] = c;
      end
      len_data = {$urandom, $urandom};
      if ($urandom_range(0, 1) == 0) len_data = '0;
      len_data[LEN_W-1:0] = LEN_W'(raw_len);

      settle();
      write_reg(REG_CHARS_0, words[0]);
      write_reg(REG_CHARS_1, words[1]);
      write_reg(REG_CHARS_2, words[2]);
      write_reg(REG_CHARS_3, words[3]);
      write_reg(REG_LENGTH, len_data);
      if ($urandom_range(0, 7) == 0) write_reg(REG_UNMAPPED, {$urandom, $urandom});
      cfg_we <= 1'b0;

      repeat ($urandom_range(3, 10)) send_subject(make_subject(), 1'b0);
      // sometimes leave a subject open across the next pattern change
      if ($urandom_range(0, 3) == 0) send_subject(make_subject(), 1'b1);
    end

    // drain and let the pipeline go quiet
    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0 && verdict_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
